// ===== rtl/sma_pkg.sv =====
// Package for the stack machine ALU: opcodes, error codes and default sizes.
// Used by the datapath, the controller and the top level; no dependencies.
package sma_pkg;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int VAR_COUNT_DEF = 256;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_LOAD = 5'd1, OP_STORE = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
    OP_MUL = 5'd5, OP_DIV = 5'd6, OP_MOD = 5'd7, OP_NEG = 5'd8, OP_PLUS = 5'd9,
    OP_GT = 5'd10, OP_LT = 5'd11, OP_EQ = 5'd12, OP_GE = 5'd13, OP_LE = 5'd14,
    OP_NE = 5'd15, OP_AND = 5'd16, OP_OR = 5'd17, OP_NOT = 5'd18, OP_PRINT = 5'd19,
    OP_DISCARD = 5'd20
  } op_t;

  localparam logic [2:0] ERR_OK = 3'd0;
  localparam logic [2:0] ERR_OVF = 3'd1;
  localparam logic [2:0] ERR_UNF = 3'd2;
  localparam logic [2:0] ERR_DIV0 = 3'd3;
  localparam logic [2:0] ERR_UNDEF = 3'd4;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_ops;   // capture operands from the memory read ports
    logic div_start;  // start the iterative divider
    logic commit;     // write back the result
  } sma_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_busy;
  } sma_sts_t;
endpackage

// ===== rtl/sma_div.sv =====
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on nothing; used by the stack machine datapath.
module sma_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [47:0] quotient,
  output logic [31:0] remainder
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic [32:0] trial;

  always_comb begin
    trial = {rem_r[31:0], q_r[47]} - {1'b0, dvs_r};
    if (!trial[32]) begin
      rem_nxt = trial;
      q_nxt = {q_r[46:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[31:0], q_r[47]};
      q_nxt = {q_r[46:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 6'd48;
      q_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != 6'd0);
  assign quotient = q_r;
  assign remainder = rem_r[31:0];
endmodule

// ===== rtl/sma_datapath.sv =====
// Datapath: value stack and variable memories, operand registers, ALU, result.
// Depends on sma_pkg and sma_div.
module sma_datapath #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF,
  parameter int VAR_COUNT = sma_pkg::VAR_COUNT_DEF,
  localparam int SPW = $clog2(STACK_DEPTH + 1),
  localparam int SAW = $clog2(STACK_DEPTH),
  localparam int VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sma_pkg::sma_cmd_t cmd,
  output sma_pkg::sma_sts_t sts,
  input  logic [4:0]        mode,
  input  logic [31:0]       operand,
  input  logic [7:0]        var_index,
  output logic [31:0]       top_value,
  output logic [8:0]        stack_depth,
  output logic [2:0]        error_code,
  output logic              printed
);
  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] var_mem [VAR_COUNT];
  logic [VAR_COUNT-1:0] def_r;
  logic [SPW-1:0] sp_r;
  logic [31:0] rd_a_r, rd_b_r, rd_v_r, a_r, b_r, v_r;
  logic [SPW-1:0] sp_m1, sp_m2;
  logic idx_ok;
  logic [VAW-1:0] vidx;

  assign sp_m1 = sp_r - SPW'(1);
  assign sp_m2 = sp_r - SPW'(2);
  assign idx_ok = ({24'd0, var_index} < 32'(VAR_COUNT));
  assign vidx = VAW'(var_index);

  // Read ports are always active and registered; the controller waits in S_READ for data.
  always_ff @(posedge clk) begin
    rd_a_r <= stk_mem[sp_m2[SAW-1:0]];
    rd_b_r <= stk_mem[sp_m1[SAW-1:0]];
    rd_v_r <= var_mem[vidx];
    if (cmd.load_ops) begin
      a_r <= rd_a_r;
      b_r <= rd_b_r;
      v_r <= rd_v_r;
    end
  end

  // Divider operands: magnitudes of a*65536 / b, or of int(a) / int(b).
  logic div_mod;
  logic [31:0] abs_a, abs_b;
  logic [47:0] dvd;
  logic [31:0] dvs;
  logic [47:0] quo;
  logic [31:0] rem;
  assign abs_a = a_r[31] ? (~a_r + 32'd1) : a_r;
  assign abs_b = b_r[31] ? (~b_r + 32'd1) : b_r;
  assign div_mod = (mode == sma_pkg::OP_MOD);
  assign dvd = div_mod ? {32'd0, abs_a[31:16]} : {abs_a, 16'd0};
  assign dvs = div_mod ? {16'd0, abs_b[31:16]} : abs_b;

  sma_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dvd), .divisor(dvs),
    .busy(sts.div_busy), .quotient(quo), .remainder(rem)
  );

  // Multiplier result registered from the operand registers.
  logic signed [63:0] prod_r;
  always_ff @(posedge clk) begin
    prod_r <= $signed(a_r) * $signed(b_r);
  end

  function automatic logic [31:0] sat64(input logic signed [64:0] v);
    if (v > 65'sh7FFF_FFFF) return sma_pkg::Q_MAX;
    if (v < -65'sh8000_0000) return sma_pkg::Q_MIN;
    return v[31:0];
  endfunction

  logic need1, need2;
  logic [31:0] r;
  logic [2:0] err;
  logic signed [64:0] ext_a, ext_b, rnd, qs, ms;
  logic [31:0] q1;
  always_comb begin
    ext_a = 65'(signed'(a_r));
    ext_b = 65'(signed'(b_r));
    rnd = (65'(prod_r) + 65'sh8000) >>> 16;
    qs = (a_r[31] ^ b_r[31]) ? -$signed({17'd0, quo}) : $signed({17'd0, quo});
    ms = a_r[31] ? -$signed({17'd0, rem, 16'd0}) : $signed({17'd0, rem, 16'd0});
    q1 = 32'd0;
    need2 = (mode >= 5'd3 && mode <= 5'd7) || (mode >= 5'd10 && mode <= 5'd17);
    need1 = (mode == 5'd2 || mode == 5'd8 || mode == 5'd9 ||
             (mode >= 5'd18 && mode <= 5'd20));
    err = sma_pkg::ERR_OK;
    r = 32'd0;
    unique case (mode)
      sma_pkg::OP_ADD:  r = sat64(ext_a + ext_b);
      sma_pkg::OP_SUB:  r = sat64(ext_a - ext_b);
      sma_pkg::OP_MUL:  r = sat64(rnd);
      sma_pkg::OP_DIV:  r = sat64(qs);
      sma_pkg::OP_MOD:  r = sat64(ms);
      sma_pkg::OP_GT:   r = ($signed(a_r) > $signed(b_r)) ? sma_pkg::Q_ONE : q1;
      sma_pkg::OP_LT:   r = ($signed(a_r) < $signed(b_r)) ? sma_pkg::Q_ONE : q1;
      sma_pkg::OP_EQ:   r = (a_r == b_r) ? sma_pkg::Q_ONE : q1;
      sma_pkg::OP_GE:   r = ($signed(a_r) >= $signed(b_r)) ? sma_pkg::Q_ONE : q1;
      sma_pkg::OP_LE:   r = ($signed(a_r) <= $signed(b_r)) ? sma_pkg::Q_ONE : q1;
      sma_pkg::OP_NE:   r = (a_r != b_r) ? sma_pkg::Q_ONE : q1;
      sma_pkg::OP_AND:  r = (a_r == sma_pkg::Q_ONE && b_r == sma_pkg::Q_ONE) ?
                            sma_pkg::Q_ONE : q1;
      sma_pkg::OP_OR:   r = (a_r == sma_pkg::Q_ONE || b_r == sma_pkg::Q_ONE) ?
                            sma_pkg::Q_ONE : q1;
      sma_pkg::OP_NEG:  r = sat64(-ext_b);
      sma_pkg::OP_NOT:  r = (b_r == 32'd0) ? sma_pkg::Q_ONE : q1;
      default:          r = b_r;
    endcase
    if (mode > 5'd20) begin
      err = sma_pkg::ERR_OK;
    end else if ((need2 && sp_r < SPW'(2)) || (need1 && sp_r == '0)) begin
      err = sma_pkg::ERR_UNF;
    end else if (mode == sma_pkg::OP_PUSH || mode == sma_pkg::OP_LOAD) begin
      if (sp_r == SPW'(STACK_DEPTH)) err = sma_pkg::ERR_OVF;
      else if (mode == sma_pkg::OP_LOAD && !(idx_ok && def_r[vidx])) err = sma_pkg::ERR_UNDEF;
    end else if (mode == sma_pkg::OP_STORE) begin
      if (!idx_ok) err = sma_pkg::ERR_UNDEF;
    end else if (mode == sma_pkg::OP_DIV && b_r == 32'd0) begin
      err = sma_pkg::ERR_DIV0;
    end else if (mode == sma_pkg::OP_MOD && b_r[31:16] == 16'd0 &&
                 (b_r[31] == 1'b0 || b_r[15:0] == 16'd0)) begin
      err = sma_pkg::ERR_DIV0;
    end else if (mode == sma_pkg::OP_MOD && abs_b[31:16] == 16'd0) begin
      err = sma_pkg::ERR_DIV0;
    end
  end

  // Write back; the output fields are registered with the new state.
  logic [SPW-1:0] sp_nxt;
  logic [31:0] top_nxt, wval;
  logic wen;
  logic [SPW-1:0] waddr;
  always_comb begin
    sp_nxt = sp_r;
    wen = 1'b0;
    waddr = sp_m1;
    wval = r;
    top_nxt = (sp_r == '0) ? 32'd0 : b_r;
    if (err == sma_pkg::ERR_OK && mode <= 5'd20) begin
      priority if (mode == sma_pkg::OP_PUSH || mode == sma_pkg::OP_LOAD) begin
        wen = 1'b1;
        waddr = sp_r;
        wval = (mode == sma_pkg::OP_PUSH) ? operand : v_r;
        sp_nxt = sp_r + SPW'(1);
        top_nxt = wval;
      end else if (need2) begin
        wen = 1'b1;
        waddr = sp_m2;
        sp_nxt = sp_m1;
        top_nxt = r;
      end else if (mode == sma_pkg::OP_PRINT || mode == sma_pkg::OP_DISCARD) begin
        sp_nxt = sp_m1;
        top_nxt = (mode == sma_pkg::OP_PRINT) ? b_r : ((sp_m1 == '0) ? 32'd0 : a_r);
      end else if (mode == sma_pkg::OP_NEG || mode == sma_pkg::OP_NOT) begin
        wen = 1'b1;
        top_nxt = r;
      end else begin
        top_nxt = b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wen) stk_mem[waddr[SAW-1:0]] <= wval;
    if (cmd.commit && err == sma_pkg::ERR_OK && mode == sma_pkg::OP_STORE)
      var_mem[vidx] <= b_r;
    if (cmd.commit) begin
      top_value <= top_nxt;
      error_code <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      def_r <= '0;
      printed <= 1'b0;
    end else if (cmd.commit) begin
      sp_r <= sp_nxt;
      printed <= (err == sma_pkg::ERR_OK && mode == sma_pkg::OP_PRINT);
      if (err == sma_pkg::ERR_OK && mode == sma_pkg::OP_STORE) def_r[vidx] <= 1'b1;
    end
  end

  assign stack_depth = 9'(sp_r);
endmodule

// ===== rtl/sma_ctrl.sv =====
// Controller: input and output handshake and sequencing of the datapath.
// Depends on sma_pkg.
module sma_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic [4:0]        mode,
  output sma_pkg::sma_cmd_t cmd,
  input  sma_pkg::sma_sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_OPS, S_MUL, S_DIV, S_WAIT, S_DONE} state_t;
  state_t state_r;
  logic outv_r;
  logic slot_free;

  assign slot_free = !outv_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = outv_r;

  always_comb begin
    cmd = '0;
    cmd.load_ops = (state_r == S_OPS);
    cmd.div_start = (state_r == S_MUL) &&
                    (mode == sma_pkg::OP_DIV || mode == sma_pkg::OP_MOD);
    cmd.commit = (state_r == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r <= 1'b0;
    end else begin
      if (cmd.commit) outv_r <= 1'b1;
      else if (out_valid && out_ready) outv_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) state_r <= S_READ;
        S_READ: state_r <= S_OPS;
        S_OPS:  state_r <= S_MUL;
        S_MUL: begin
          if (mode == sma_pkg::OP_DIV || mode == sma_pkg::OP_MOD) state_r <= S_DIV;
          else state_r <= S_DONE;
        end
        S_DIV:  state_r <= S_WAIT;
        S_WAIT: if (!sts.div_busy) state_r <= S_DONE;
        S_DONE: if (cmd.commit) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/stack_machine_alu.sv =====
// Stack machine ALU: one postfix instruction per transfer, one result each.
// The sequencer steps through the read, operand and multiply states and, for
// divide and modulo, the divider states before the result is committed. A new
// instruction is accepted only after the current result has been committed,
// and commit waits until the output slot is free. Synchronous active-low reset
// clears the stack pointer and the defined flags; memory contents are left unspecified.
module stack_machine_alu #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF,
  parameter int VAR_COUNT = sma_pkg::VAR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mode[4:0], operand[36:5], var_index[44:37], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // top_value[31:0], stack_depth[40:32],
                                  // error_code[43:41], printed[44], zero pad
);
  sma_pkg::sma_cmd_t cmd;
  sma_pkg::sma_sts_t sts;
  logic [4:0] mode_r;
  logic [31:0] opnd_r;
  logic [7:0] vidx_r;
  logic [31:0] top_value;
  logic [8:0] stack_depth;
  logic [2:0] error_code;
  logic printed;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_tdata[4:0];
      opnd_r <= in_tdata[36:5];
      vidx_r <= in_tdata[44:37];
    end
  end

  sma_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .mode(mode_r), .cmd(cmd), .sts(sts)
  );

  sma_datapath #(.STACK_DEPTH(STACK_DEPTH), .VAR_COUNT(VAR_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .mode(mode_r), .operand(opnd_r),
    .var_index(vidx_r), .top_value(top_value), .stack_depth(stack_depth),
    .error_code(error_code), .printed(printed)
  );

  assign out_tdata = {3'd0, printed, error_code, stack_depth, top_value};
endmodule

// ===== rtl/sma_checker.sv =====
// Port-level checker for the stack machine ALU, attached by bind.
// Depends on the top level's ports only.
module sma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[43:41] <= 3'd4) else $error("bad error code");
  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44] |-> out_tdata[43:41] == 3'd0) else $error("print with error");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("output dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted while busy");
endmodule

bind stack_machine_alu sma_checker u_sma_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
